// ===== rtl/qdc_pkg.sv =====
// ----------------------------------------------------------------------------
// qdc_pkg
// Shared types, register codes, reset values and the Gray-code step table
// for the quadrature detent counter.
// ----------------------------------------------------------------------------
package qdc_pkg;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_POLL   = 2'd1,
        ACT_HAPTIC = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_REVERSE_DIRECTION = 2'd0,
        CFG_DELTA_LIMIT       = 2'd1,
        CFG_PULSE_TICKS       = 2'd2,
        CFG_PULSE_COMMAND     = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic [1:0] action;
        logic       pin_a;
        logic       pin_b;
        logic [7:0] command_byte;
    } in_word_t;

    typedef struct packed {
        logic              report_valid;
        logic signed [7:0] report_delta;
        logic [7:0]        report_seq;
        logic              haptic_drive;
    } out_word_t;

    typedef struct packed {
        logic       reverse_direction;
        logic [6:0] delta_limit;
        logic [7:0] pulse_ticks;
        logic [7:0] pulse_command;
    } cfg_t;

    localparam logic       RESET_REVERSE_DIRECTION = 1'b0;
    localparam logic [6:0] RESET_DELTA_LIMIT       = 7'd120;
    localparam logic [7:0] RESET_PULSE_TICKS       = 8'd60;
    localparam logic [7:0] RESET_PULSE_COMMAND     = 8'd1;

    localparam logic signed [3:0] QUARTER_UP   = 4'sd4;
    localparam logic signed [3:0] QUARTER_DOWN = -4'sd4;

    // index is {previous pins, current pins}
    function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
        logic signed [1:0] step;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default: step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

// ===== rtl/qdc_cfg.sv =====
// ----------------------------------------------------------------------------
// qdc_cfg
// Configuration register file: decodes the write channel and holds the
// four control registers.
// ----------------------------------------------------------------------------
module qdc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  qdc_pkg::cfg_index_t         cfg_index,
    input  logic [qdc_pkg::CFG_DATA_W-1:0] cfg_data,
    output qdc_pkg::cfg_t               cfg
);
    import qdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REVERSE_DIRECTION: cfg_next.reverse_direction = cfg_data[0];
                CFG_DELTA_LIMIT:       cfg_next.delta_limit       = cfg_data[6:0];
                CFG_PULSE_TICKS:       cfg_next.pulse_ticks       = cfg_data;
                CFG_PULSE_COMMAND:     cfg_next.pulse_command     = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reverse_direction <= RESET_REVERSE_DIRECTION;
            cfg_reg.delta_limit       <= RESET_DELTA_LIMIT;
            cfg_reg.pulse_ticks       <= RESET_PULSE_TICKS;
            cfg_reg.pulse_command     <= RESET_PULSE_COMMAND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

`ifndef SYNTHESIS
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_valid) |-> $stable(cfg_reg))
        else $error("configuration changed without a write");
`endif

endmodule

// ===== rtl/qdc_core.sv =====
// ----------------------------------------------------------------------------
// qdc_core
// Encoder state, detent accumulation, poll readout and haptic countdown;
// forms the result word of each accepted input word.
// ----------------------------------------------------------------------------
module qdc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  qdc_pkg::in_word_t  in_word,
    input  qdc_pkg::cfg_t      cfg,
    output qdc_pkg::out_word_t result
);
    import qdc_pkg::*;

    logic [1:0]        last_pins_reg, last_pins_next;
    logic              primed_reg, primed_next;
    logic signed [3:0] quarter_reg, quarter_next;
    logic signed [7:0] pending_reg, pending_next;
    logic [7:0]        sequence_reg, sequence_next;
    logic [7:0]        pulse_reg, pulse_next;

    logic [1:0]        pins;
    logic signed [1:0] step;
    logic signed [3:0] step_ext;
    logic signed [3:0] quarter_sum;
    logic              detent;
    logic              detent_up;
    logic signed [8:0] pending_ext;
    logic signed [8:0] limit_ext;

    assign pins        = {in_word.pin_a, in_word.pin_b};
    assign step        = gray_step({last_pins_reg, pins});
    assign step_ext    = {{2{step[1]}}, step};
    assign quarter_sum = quarter_reg + step_ext;
    assign pending_ext = {pending_reg[7], pending_reg};
    assign limit_ext   = {2'b00, cfg.delta_limit};

    always_comb
    begin
        last_pins_next = last_pins_reg;
        primed_next    = primed_reg;
        quarter_next   = quarter_reg;
        pending_next   = pending_reg;
        sequence_next  = sequence_reg;
        pulse_next     = pulse_reg;
        detent         = 1'b0;
        detent_up      = 1'b0;
        result         = '0;

        case (in_word.action)
            ACT_TICK:
            begin
                if (!primed_reg)
                begin
                    primed_next    = 1'b1;
                    last_pins_next = pins;
                end
                else if (pins != last_pins_reg)
                begin
                    last_pins_next = pins;
                    quarter_next   = quarter_sum;
                    if (quarter_sum >= QUARTER_UP)
                    begin
                        detent       = 1'b1;
                        detent_up    = 1'b1;
                        quarter_next = '0;
                    end
                    else if (quarter_sum <= QUARTER_DOWN)
                    begin
                        detent       = 1'b1;
                        quarter_next = '0;
                    end
                end
                if (pulse_reg != 8'd0)
                begin
                    pulse_next = pulse_reg - 8'd1;
                end
            end
            ACT_POLL:
            begin
                result.report_valid = 1'b1;
                result.report_delta = pending_reg;
                result.report_seq   = sequence_reg;
                pending_next        = '0;
                sequence_next       = sequence_reg + 8'd1;
            end
            ACT_HAPTIC:
            begin
                if (in_word.command_byte == cfg.pulse_command)
                begin
                    pulse_next = cfg.pulse_ticks;
                end
            end
            default:
            begin
                pulse_next = pulse_reg;
            end
        endcase

        // saturate against the limit, never wrap
        if (detent)
        begin
            if (detent_up ^ cfg.reverse_direction)
            begin
                if (pending_ext < limit_ext)
                begin
                    pending_next = pending_reg + 8'sd1;
                end
            end
            else if (pending_ext > -limit_ext)
            begin
                pending_next = pending_reg - 8'sd1;
            end
        end

        result.haptic_drive = (pulse_next != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg <= '0;
            primed_reg    <= 1'b0;
            quarter_reg   <= '0;
            pending_reg   <= '0;
            sequence_reg  <= '0;
            pulse_reg     <= '0;
        end
        else if (accept)
        begin
            last_pins_reg <= last_pins_next;
            primed_reg    <= primed_next;
            quarter_reg   <= quarter_next;
            pending_reg   <= pending_next;
            sequence_reg  <= sequence_next;
            pulse_reg     <= pulse_next;
        end
    end

`ifndef SYNTHESIS
    a_quarter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (quarter_reg < QUARTER_UP) && (quarter_reg > QUARTER_DOWN))
        else $error("quarter count left its range");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != -8'sd128)
        else $error("pending delta reached an unreportable value");

    a_poll_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_word.action == ACT_POLL)
        |=> (pending_reg == 8'sd0) && (sequence_reg == $past(sequence_reg) + 8'd1))
        else $error("poll did not clear delta or advance sequence");

    a_pulse_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pulse_reg) && $stable(pending_reg))
        else $error("state moved without an accepted word");
`endif

endmodule

// ===== rtl/quadrature_detent_counter_haptic_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_counter_haptic_top
// Quadrature encoder detent counter with host poll and haptic pulse output.
// Output: the result is valid in the output register in the cycle after input acceptance.
// Throughput: one word per cycle; input ready is held low only while the
//   output register holds a result that is not being taken.
// Reset: asynchronous active low; clears all encoder state, loads register defaults.
// ----------------------------------------------------------------------------
module quadrature_detent_counter_haptic_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  qdc_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output qdc_pkg::out_word_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  qdc_pkg::cfg_index_t            cfg_index,
    input  logic [qdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import qdc_pkg::*;

    cfg_t      cfg;
    out_word_t result;
    logic      accept;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;

    qdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qdc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_word (in_data),
        .cfg     (cfg),
        .result  (result)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_non_poll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.report_valid
        |-> (out_data.report_delta == 8'sd0) && (out_data.report_seq == 8'd0))
        else $error("non-poll result carries report fields");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !accept)
        else $error("pending result overwritten");
`endif

endmodule
